// File: src/bgpt_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bgpt_pkg - beat grid phase tracker shared types and microcode
// Beat structs for both channels, sequencer control word layout and the
// program that the sequencer steps through.
// ---------------------------------------------------------------------------
package bgpt_pkg;

   localparam int unsigned TIME_W      = 64;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned PERIOD_W    = 32;
   localparam int unsigned PROG_W      = 8;
   localparam int unsigned FRAC_W      = 8;
   localparam int unsigned FLAGS_W     = 3;
   localparam int unsigned DIV_STEPS   = TIME_W;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int unsigned UPC_W       = 5;

   localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = 32'd10000;

   // update flag bit positions
   localparam int unsigned FLAG_TIME_REF = 0;
   localparam int unsigned FLAG_TEMPO    = 1;
   localparam int unsigned FLAG_PROGRAM  = 2;

   localparam logic CMD_FRAME_TICK = 1'b0;
   localparam logic CMD_CONTROL    = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [FLAGS_W-1:0]  update_flags;
      logic [TIME_W-1:0]   now_us;
      logic [TIME_W-1:0]   after_us;
      logic [TIME_W-1:0]   announced_ref_us;
      logic [COUNT_W-1:0]  announced_count;
      logic [PERIOD_W-1:0] announced_period_us;
      logic [PROG_W-1:0]   announced_program;
   } req_type;

   typedef struct packed {
      logic                frame_valid;
      logic [FRAC_W-1:0]   phase_frac;
      logic [COUNT_W-1:0]  beat_index;
      logic [PROG_W-1:0]   prog_sel;
      logic [PERIOD_W-1:0] wake_us;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD_DN,
      OP_LOAD_UP,
      OP_LOAD_ADV,
      OP_DIV_STEP,
      OP_TR_DN_FIN,
      OP_TR_UP_FIN,
      OP_TR_KEEP,
      OP_TR_FLAT,
      OP_LAST_FROM_NEXT,
      OP_NEXT_FROM_LAST,
      OP_ADV_FIN,
      OP_TEMPO_UPD,
      OP_CTRL_OUT,
      OP_FRAC_INIT,
      OP_FRAC_STEP,
      OP_FRAC_FULL,
      OP_TICK_OUT,
      OP_IDLE_OUT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_TICK,
      C_NO_TREF,
      C_TEMPO_ZERO,
      C_REF_LE_NOW,
      C_REF_NEAR,
      C_DIV_BUSY,
      C_GRID_IDLE,
      C_NOT_BEHIND,
      C_SPAN_ZERO,
      C_POS_GE_SPAN,
      C_FRAC_BUSY
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } uword_type;

   // program labels
   localparam logic [UPC_W-1:0] L_ROLL_DN_LAST = 5'd8;
   localparam logic [UPC_W-1:0] L_TR_KEEP      = 5'd9;
   localparam logic [UPC_W-1:0] L_TR_UP        = 5'd10;
   localparam logic [UPC_W-1:0] L_TR_FLAT      = 5'd14;
   localparam logic [UPC_W-1:0] L_TEMPO        = 5'd15;
   localparam logic [UPC_W-1:0] L_TICK         = 5'd17;
   localparam logic [UPC_W-1:0] L_FRAC         = 5'd23;
   localparam logic [UPC_W-1:0] L_TICK_OUT     = 5'd27;
   localparam logic [UPC_W-1:0] L_FRAC_FULL    = 5'd28;
   localparam logic [UPC_W-1:0] L_IDLE         = 5'd29;

   function automatic uword_type ucode_word(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '{OP_NOP, C_NEVER, '0};
      unique case (addr)
         5'd0:  w = '{OP_NOP,            C_TICK,        L_TICK};
         5'd1:  w = '{OP_NOP,            C_NO_TREF,     L_TEMPO};
         5'd2:  w = '{OP_NOP,            C_TEMPO_ZERO,  L_TR_FLAT};
         5'd3:  w = '{OP_NOP,            C_REF_LE_NOW,  L_TR_UP};
         5'd4:  w = '{OP_NOP,            C_REF_NEAR,    L_TR_KEEP};
         5'd5:  w = '{OP_LOAD_DN,        C_NEVER,       '0};
         5'd6:  w = '{OP_DIV_STEP,       C_DIV_BUSY,    5'd6};
         5'd7:  w = '{OP_TR_DN_FIN,      C_NEVER,       '0};
         5'd8:  w = '{OP_LAST_FROM_NEXT, C_ALWAYS,      L_TEMPO};
         5'd9:  w = '{OP_TR_KEEP,        C_ALWAYS,      L_ROLL_DN_LAST};
         5'd10: w = '{OP_LOAD_UP,        C_NEVER,       '0};
         5'd11: w = '{OP_DIV_STEP,       C_DIV_BUSY,    5'd11};
         5'd12: w = '{OP_TR_UP_FIN,      C_NEVER,       '0};
         5'd13: w = '{OP_NEXT_FROM_LAST, C_ALWAYS,      L_TEMPO};
         5'd14: w = '{OP_TR_FLAT,        C_NEVER,       '0};
         5'd15: w = '{OP_TEMPO_UPD,      C_NEVER,       '0};
         5'd16: w = '{OP_CTRL_OUT,       C_NEVER,       '0};
         5'd17: w = '{OP_NOP,            C_GRID_IDLE,   L_IDLE};
         5'd18: w = '{OP_NOP,            C_NOT_BEHIND,  L_FRAC};
         5'd19: w = '{OP_LOAD_ADV,       C_NEVER,       '0};
         5'd20: w = '{OP_DIV_STEP,       C_DIV_BUSY,    5'd20};
         5'd21: w = '{OP_ADV_FIN,        C_NEVER,       '0};
         5'd22: w = '{OP_NEXT_FROM_LAST, C_NEVER,       '0};
         5'd23: w = '{OP_FRAC_INIT,      C_NEVER,       '0};
         5'd24: w = '{OP_NOP,            C_SPAN_ZERO,   L_TICK_OUT};
         5'd25: w = '{OP_NOP,            C_POS_GE_SPAN, L_FRAC_FULL};
         5'd26: w = '{OP_FRAC_STEP,      C_FRAC_BUSY,   5'd26};
         5'd27: w = '{OP_TICK_OUT,       C_NEVER,       '0};
         5'd28: w = '{OP_FRAC_FULL,      C_ALWAYS,      L_TICK_OUT};
         5'd29: w = '{OP_IDLE_OUT,       C_NEVER,       '0};
         default: w = '{OP_IDLE_OUT,     C_NEVER,       '0};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// File: src/beat_grid_phase_tracker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// beat_grid_phase_tracker - beat grid keeper with microcoded sequencer
// Holds the beat grid, applies control messages and answers frame ticks
// with beat fraction, beat count, program id and wake delay.
// ---------------------------------------------------------------------------
// One beat in gives one beat out. Beats are worked one at a time by a small
// microcoded sequencer; a new request is taken as soon as the previous one
// has finished, even while its response still waits in the output register.
// A control message that rolls the time reference and a frame tick that has
// to advance the grid both run the shared restoring divider, which retires
// one quotient bit per cycle over the 64-bit time difference; the beat
// fraction takes one halving step per cycle for its 8 bits. The finishing
// step also waits while the previous response is still held in the output
// register.
module beat_grid_phase_tracker (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire bgpt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output bgpt_pkg::rsp_type     rsp_data,
   input  wire                   csr_wr_en,
   input  wire [bgpt_pkg::PERIOD_W-1:0] csr_wr_data
);

   localparam int unsigned TW = bgpt_pkg::TIME_W;
   localparam int unsigned CW = bgpt_pkg::COUNT_W;
   localparam int unsigned PW = bgpt_pkg::PERIOD_W;

   // control
   logic                              busy_ff, busy_in;
   logic [bgpt_pkg::UPC_W-1:0]        upc_ff, upc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]                     frame_period_ff, frame_period_in;
   // grid state
   logic [TW-1:0]                     ref_time_ff, ref_time_in;
   logic [PW-1:0]                     tempo_ff, tempo_in;
   logic [TW-1:0]                     last_ff, last_in;
   logic [TW-1:0]                     next_ff, next_in;
   logic [CW-1:0]                     number_ff, number_in;
   logic [bgpt_pkg::PROG_W-1:0]       program_ff, program_in;
   logic [bgpt_pkg::FRAC_W-1:0]       frac_mask_ff, frac_mask_in;
   // working registers
   bgpt_pkg::req_type                 item_ff, item_in;
   bgpt_pkg::rsp_type                 rsp_ff, rsp_in;
   logic [TW-1:0]                     x_ff, x_in;
   logic [CW-1:0]                     q_ff, q_in;
   logic [PW-1:0]                     r_ff, r_in;
   logic [bgpt_pkg::DIV_CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [TW-1:0]                     pos_ff, pos_in;
   logic [TW-1:0]                     span_ff, span_in;
   logic [bgpt_pkg::FRAC_W-1:0]       frac_ff, frac_in;

   bgpt_pkg::uword_type               uword;
   logic                              is_out_op;
   logic                              step_en;
   logic                              jump;
   logic [PW:0]                       div_trial;
   logic [PW:0]                       div_diff;
   logic                              div_ge;
   logic [TW-1:0]                     half_span;
   logic [TW-1:0]                     wake_rem;

   assign uword     = bgpt_pkg::ucode_word(upc_ff);
   assign is_out_op = (uword.op == bgpt_pkg::OP_CTRL_OUT) ||
                      (uword.op == bgpt_pkg::OP_TICK_OUT) ||
                      (uword.op == bgpt_pkg::OP_IDLE_OUT);
   // a finishing step waits for room in the output register
   assign step_en   = busy_ff && !(is_out_op && rsp_valid_ff && !rsp_ready);

   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // restoring divider step, divisor is the tempo period
   assign div_trial = {r_ff, x_ff[TW-1]};
   assign div_diff  = div_trial - {1'b0, tempo_ff};
   assign div_ge    = div_trial >= {1'b0, tempo_ff};
   assign half_span = span_ff >> 1;
   assign wake_rem  = next_ff - item_ff.after_us;

   always_comb begin
      unique case (uword.cond)
         bgpt_pkg::C_NEVER:       jump = 1'b0;
         bgpt_pkg::C_ALWAYS:      jump = 1'b1;
         bgpt_pkg::C_TICK:        jump = item_ff.cmd == bgpt_pkg::CMD_FRAME_TICK;
         bgpt_pkg::C_NO_TREF:     jump = !item_ff.update_flags[bgpt_pkg::FLAG_TIME_REF];
         bgpt_pkg::C_TEMPO_ZERO:  jump = tempo_ff == '0;
         bgpt_pkg::C_REF_LE_NOW:  jump = item_ff.announced_ref_us <= item_ff.now_us;
         bgpt_pkg::C_REF_NEAR:    jump = (item_ff.announced_ref_us - item_ff.now_us)
                                         <= {{(TW-PW){1'b0}}, tempo_ff};
         bgpt_pkg::C_DIV_BUSY:    jump = div_cnt_ff != bgpt_pkg::DIV_CNT_W'(bgpt_pkg::DIV_STEPS - 1);
         bgpt_pkg::C_GRID_IDLE:   jump = (ref_time_ff == '0) || (tempo_ff == '0);
         bgpt_pkg::C_NOT_BEHIND:  jump = next_ff >= item_ff.now_us;
         bgpt_pkg::C_SPAN_ZERO:   jump = span_ff == '0;
         bgpt_pkg::C_POS_GE_SPAN: jump = pos_ff >= span_ff;
         bgpt_pkg::C_FRAC_BUSY:   jump = !frac_mask_ff[0];
         default:                 jump = 1'b0;
      endcase
   end

   always_comb begin
      busy_in         = busy_ff;
      upc_in          = upc_ff;
      rsp_valid_in    = rsp_valid_ff;
      frame_period_in = frame_period_ff;
      ref_time_in     = ref_time_ff;
      tempo_in        = tempo_ff;
      last_in         = last_ff;
      next_in         = next_ff;
      number_in       = number_ff;
      program_in      = program_ff;
      frac_mask_in    = frac_mask_ff;
      item_in         = item_ff;
      rsp_in          = rsp_ff;
      x_in            = x_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      div_cnt_in      = div_cnt_ff;
      pos_in          = pos_ff;
      span_in         = span_ff;
      frac_in         = frac_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_valid && !busy_ff) begin
         item_in = req_data;
         upc_in  = '0;
         busy_in = 1'b1;
      end

      if (step_en) begin
         upc_in = jump ? uword.target : upc_ff + 1'b1;
         unique case (uword.op)
            bgpt_pkg::OP_NOP: begin
            end
            bgpt_pkg::OP_LOAD_DN: begin
               x_in       = item_ff.announced_ref_us - item_ff.now_us - 64'd1;
               r_in       = '0;
               div_cnt_in = '0;
            end
            bgpt_pkg::OP_LOAD_UP: begin
               x_in       = item_ff.now_us - item_ff.announced_ref_us;
               r_in       = '0;
               div_cnt_in = '0;
            end
            bgpt_pkg::OP_LOAD_ADV: begin
               x_in       = item_ff.now_us - next_ff - 64'd1;
               r_in       = '0;
               div_cnt_in = '0;
            end
            bgpt_pkg::OP_DIV_STEP: begin
               r_in       = div_ge ? div_diff[PW-1:0] : div_trial[PW-1:0];
               q_in       = {q_ff[CW-2:0], div_ge};
               x_in       = {x_ff[TW-2:0], 1'b0};
               div_cnt_in = div_cnt_ff + 1'b1;
            end
            // rolled back: ref - q*p equals now + 1 + remainder
            bgpt_pkg::OP_TR_DN_FIN: begin
               next_in     = item_ff.now_us + 64'd1 + {{(TW-PW){1'b0}}, r_ff};
               number_in   = item_ff.announced_count - q_ff;
               ref_time_in = item_ff.announced_ref_us;
            end
            // rolled forward: last boundary is now minus remainder
            bgpt_pkg::OP_TR_UP_FIN: begin
               last_in     = item_ff.now_us - {{(TW-PW){1'b0}}, r_ff};
               number_in   = item_ff.announced_count + q_ff + 32'd1;
               ref_time_in = item_ff.announced_ref_us;
            end
            bgpt_pkg::OP_TR_KEEP: begin
               next_in     = item_ff.announced_ref_us;
               number_in   = item_ff.announced_count;
               ref_time_in = item_ff.announced_ref_us;
            end
            bgpt_pkg::OP_TR_FLAT: begin
               next_in     = item_ff.announced_ref_us;
               last_in     = item_ff.announced_ref_us;
               number_in   = item_ff.announced_count;
               ref_time_in = item_ff.announced_ref_us;
            end
            bgpt_pkg::OP_LAST_FROM_NEXT: begin
               last_in = next_ff - {{(TW-PW){1'b0}}, tempo_ff};
            end
            bgpt_pkg::OP_NEXT_FROM_LAST: begin
               next_in = last_ff + {{(TW-PW){1'b0}}, tempo_ff};
            end
            bgpt_pkg::OP_ADV_FIN: begin
               last_in   = item_ff.now_us - 64'd1 - {{(TW-PW){1'b0}}, r_ff};
               number_in = number_ff + q_ff + 32'd1;
            end
            bgpt_pkg::OP_TEMPO_UPD: begin
               if (item_ff.update_flags[bgpt_pkg::FLAG_TEMPO]) begin
                  tempo_in = item_ff.announced_period_us;
                  // first tempo starts the grid at now
                  if (ref_time_ff == '0 && item_ff.announced_period_us != '0) begin
                     ref_time_in = item_ff.now_us;
                     last_in     = item_ff.now_us;
                     next_in     = item_ff.now_us +
                                   {{(TW-PW){1'b0}}, item_ff.announced_period_us};
                     number_in   = 32'd1;
                  end
               end
            end
            bgpt_pkg::OP_CTRL_OUT: begin
               if (item_ff.update_flags[bgpt_pkg::FLAG_PROGRAM]) begin
                  program_in = item_ff.announced_program;
               end
               rsp_in.frame_valid = 1'b0;
               rsp_in.phase_frac  = '0;
               rsp_in.beat_index  = '0;
               rsp_in.wake_us     = '0;
               rsp_in.prog_sel    = item_ff.update_flags[bgpt_pkg::FLAG_PROGRAM] ?
                                    item_ff.announced_program : program_ff;
               rsp_valid_in       = 1'b1;
               busy_in            = 1'b0;
            end
            bgpt_pkg::OP_FRAC_INIT: begin
               pos_in       = item_ff.now_us - last_ff;
               span_in      = next_ff - last_ff;
               frac_in      = '0;
               frac_mask_in = {1'b1, {(bgpt_pkg::FRAC_W-1){1'b0}}};
            end
            // halve the span, take one fraction bit per step
            bgpt_pkg::OP_FRAC_STEP: begin
               span_in      = half_span;
               frac_mask_in = {frac_mask_ff[0], frac_mask_ff[bgpt_pkg::FRAC_W-1:1]};
               if (pos_ff >= half_span) begin
                  pos_in  = pos_ff - half_span;
                  frac_in = frac_ff | frac_mask_ff;
               end
            end
            bgpt_pkg::OP_FRAC_FULL: begin
               frac_in = '1;
            end
            bgpt_pkg::OP_TICK_OUT: begin
               rsp_in.frame_valid = 1'b1;
               rsp_in.phase_frac  = frac_ff;
               rsp_in.beat_index  = number_ff - 32'd1;
               rsp_in.prog_sel    = program_ff;
               rsp_in.wake_us     = frame_period_ff;
               if (next_ff > item_ff.after_us &&
                   wake_rem < {{(TW-PW){1'b0}}, frame_period_ff}) begin
                  rsp_in.wake_us = wake_rem[PW-1:0];
               end
               rsp_valid_in = 1'b1;
               busy_in      = 1'b0;
            end
            bgpt_pkg::OP_IDLE_OUT: begin
               rsp_in.frame_valid = 1'b0;
               rsp_in.phase_frac  = '0;
               rsp_in.beat_index  = '0;
               rsp_in.prog_sel    = program_ff;
               rsp_in.wake_us     = frame_period_ff;
               rsp_valid_in       = 1'b1;
               busy_in            = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (csr_wr_en) begin
         frame_period_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         upc_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         frame_period_ff <= bgpt_pkg::FRAME_PERIOD_RESET;
         ref_time_ff     <= '0;
         tempo_ff        <= '0;
         last_ff         <= '0;
         next_ff         <= '0;
         number_ff       <= '0;
         program_ff      <= '0;
         frac_mask_ff    <= {1'b1, {(bgpt_pkg::FRAC_W-1){1'b0}}};
      end else begin
         busy_ff         <= busy_in;
         upc_ff          <= upc_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_period_ff <= frame_period_in;
         ref_time_ff     <= ref_time_in;
         tempo_ff        <= tempo_in;
         last_ff         <= last_in;
         next_ff         <= next_in;
         number_ff       <= number_in;
         program_ff      <= program_in;
         frac_mask_ff    <= frac_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
      x_ff       <= x_in;
      q_ff       <= q_in;
      r_ff       <= r_in;
      div_cnt_ff <= div_cnt_in;
      pos_ff     <= pos_in;
      span_ff    <= span_in;
      frac_ff    <= frac_in;
   end

   // a finished beat always leaves a response behind
   a_done_has_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> rsp_valid_ff)
      else $error("beat finished without a response");

   // the divider only runs with a nonzero tempo period
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uword.op == bgpt_pkg::OP_DIV_STEP) |-> (tempo_ff != '0))
      else $error("division by a zero tempo period");

   // the fraction bit pointer never loses or gains a bit
   a_frac_mask: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot(frac_mask_ff))
      else $error("fraction bit pointer corrupted");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_top - self-checking testbench for beat_grid_phase_tracker
// Sends directed and random beats (control messages and frame ticks) through
// the request channel, keeps a shadow beat grid that works out every response,
// and compares the responses field by field under random back-pressure.
// ---------------------------------------------------------------------------

class beat_grid_shadow;

   logic [31:0] frame_period;
   logic [63:0] ref_time;
   logic [31:0] tempo;
   logic [63:0] last_beat;
   logic [63:0] next_beat;
   logic [31:0] next_count;
   logic [7:0]  prog_id;
   bgpt_pkg::rsp_type awaited_rsp[$];
   int unsigned mismatches;

   function new();
      frame_period = bgpt_pkg::FRAME_PERIOD_RESET;
      ref_time     = '0;
      tempo        = '0;
      last_beat    = '0;
      next_beat    = '0;
      next_count   = '0;
      prog_id      = '0;
      mismatches   = 0;
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      mismatches++;
   endtask

   // position within the beat in 1/256 steps, one halving per bit
   function logic [7:0] beat_fraction(logic [63:0] pos, logic [63:0] span);
      logic [7:0] acc;
      acc = '0;
      if (span == 0) return 8'd0;
      if (pos >= span) return 8'hFF;
      for (int i = 0; i < 8; i++) begin
         span = span >> 1;
         if (pos >= span) begin
            acc[7-i] = 1'b1;
            pos      = pos - span;
         end
      end
      return acc;
   endfunction

   // move the announced boundary to the first one after now
   function void roll_boundary(logic [63:0] now, logic [63:0] bound, logic [31:0] count);
      logic [63:0] p;
      logic [63:0] k;
      p = {32'd0, tempo};
      if (p != 0) begin
         if (bound <= now) begin
            k     = (now - bound) / p + 1;
            bound = bound + k * p;
            count = count + k[31:0];
         end else if (bound - now > p) begin
            k     = (bound - now - 1) / p;
            bound = bound - k * p;
            count = count - k[31:0];
         end
         last_beat = bound - p;
      end else begin
         last_beat = bound;
      end
      next_beat  = bound;
      next_count = count;
   endfunction

   function void note_request(bgpt_pkg::req_type r);
      bgpt_pkg::rsp_type e;
      logic [63:0] p;
      logic [63:0] k;
      logic [63:0] rem;
      logic [31:0] wake;
      e = '0;
      if (r.cmd == bgpt_pkg::CMD_CONTROL) begin
         if (r.update_flags[bgpt_pkg::FLAG_TIME_REF]) begin
            roll_boundary(r.now_us, r.announced_ref_us, r.announced_count);
            ref_time = r.announced_ref_us;
         end
         if (r.update_flags[bgpt_pkg::FLAG_TEMPO]) begin
            tempo = r.announced_period_us;
            if (ref_time == 0 && r.announced_period_us != 0) begin
               ref_time   = r.now_us;
               last_beat  = r.now_us;
               next_beat  = r.now_us + {32'd0, r.announced_period_us};
               next_count = 32'd1;
            end
         end
         if (r.update_flags[bgpt_pkg::FLAG_PROGRAM]) prog_id = r.announced_program;
         e.prog_sel = prog_id;
      end else if (ref_time == 0 || tempo == 0) begin
         e.prog_sel = prog_id;
         e.wake_us  = frame_period;
      end else begin
         p = {32'd0, tempo};
         if (next_beat < r.now_us) begin
            k          = (r.now_us - next_beat - 1) / p + 1;
            last_beat  = next_beat + (k - 1) * p;
            next_beat  = last_beat + p;
            next_count = next_count + k[31:0];
         end
         e.frame_valid = 1'b1;
         e.phase_frac  = beat_fraction(r.now_us - last_beat, next_beat - last_beat);
         e.beat_index  = next_count - 32'd1;
         e.prog_sel    = prog_id;
         wake = frame_period;
         if (next_beat > r.after_us) begin
            rem = next_beat - r.after_us;
            if (rem < {32'd0, frame_period}) wake = rem[31:0];
         end
         e.wake_us = wake;
      end
      awaited_rsp.push_back(e);
   endfunction

   task check_response(bgpt_pkg::rsp_type got);
      bgpt_pkg::rsp_type want;
      if (awaited_rsp.size() == 0) begin
         report_mismatch("response with none awaited", {32'd0, got.beat_index}, 64'd0);
      end else begin
         want = awaited_rsp.pop_front();
         if (got.frame_valid !== want.frame_valid)
            report_mismatch("frame_valid", {63'd0, got.frame_valid}, {63'd0, want.frame_valid});
         if (got.phase_frac !== want.phase_frac)
            report_mismatch("phase_frac", {56'd0, got.phase_frac}, {56'd0, want.phase_frac});
         if (got.beat_index !== want.beat_index)
            report_mismatch("beat_index", {32'd0, got.beat_index}, {32'd0, want.beat_index});
         if (got.prog_sel !== want.prog_sel)
            report_mismatch("prog_sel", {56'd0, got.prog_sel}, {56'd0, want.prog_sel});
         if (got.wake_us !== want.wake_us)
            report_mismatch("wake_us", {32'd0, got.wake_us}, {32'd0, want.wake_us});
      end
   endtask

endclass

module tb_top;

   localparam int CLK_HALF        = 6;
   localparam int RESET_CYCLES    = 4;
   localparam int BEATS_PER_PHASE = 267;
   localparam int PHASES          = 6;
   localparam int LONG_HOLD       = 500;
   localparam int SETTLE_CYCLES   = 200;
   localparam int TIMEOUT_CYCLES  = 1500000;

   localparam logic [2:0] UPD_NONE  = 3'b000;
   localparam logic [2:0] UPD_TREF  = 3'(1 << bgpt_pkg::FLAG_TIME_REF);
   localparam logic [2:0] UPD_TEMPO = 3'(1 << bgpt_pkg::FLAG_TEMPO);
   localparam logic [2:0] UPD_PROG  = 3'(1 << bgpt_pkg::FLAG_PROGRAM);
   localparam logic [2:0] UPD_ALL   = UPD_TREF | UPD_TEMPO | UPD_PROG;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_ready;
   bgpt_pkg::req_type        req_data    = '0;
   logic                     rsp_valid;
   logic                     rsp_ready   = 1'b0;
   bgpt_pkg::rsp_type        rsp_data;
   logic                     csr_wr_en   = 1'b0;
   logic [31:0]              csr_wr_data = '0;

   int unsigned req_idle_pct = 16;
   int unsigned rsp_idle_pct = 45;
   int unsigned stall_orders = 0;
   int unsigned stall_taken  = 0;
   int unsigned hold_left    = 0;

   logic [63:0] wall_us    = 64'd5000000;
   logic [31:0] tempo_hint = 32'd500000;

   beat_grid_shadow grid_shadow = new();

   beat_grid_phase_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // responses are matched before the beat taken at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) grid_shadow.check_response(rsp_data);
         if (req_valid && req_ready) grid_shadow.note_request(req_data);
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (stall_taken != stall_orders) begin
         stall_taken = stall_orders;
         hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      #(2 * CLK_HALF * TIMEOUT_CYCLES);
      $display("beat_grid_phase_tracker test failed");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bgpt_pkg::req_type make_beat(logic cmd, logic [2:0] flags,
         logic [63:0] now, logic [63:0] after, logic [63:0] aref,
         logic [31:0] count, logic [31:0] period, logic [7:0] prog);
      bgpt_pkg::req_type b;
      b.cmd                 = cmd;
      b.update_flags        = flags;
      b.now_us              = now;
      b.after_us            = after;
      b.announced_ref_us    = aref;
      b.announced_count     = count;
      b.announced_period_us = period;
      b.announced_program   = prog;
      return b;
   endfunction

   // mostly well-formed grid traffic on a running clock, a little noise
   function automatic bgpt_pkg::req_type random_beat();
      bgpt_pkg::req_type b;
      int unsigned kind;
      int unsigned roll;
      logic [63:0] span;
      kind = $urandom_range(99);
      roll = $urandom_range(99);
      span = {32'd0, tempo_hint};
      b = make_beat(1'($urandom_range(1)), 3'($urandom_range(7)), rand64(), rand64(),
                    rand64(), $urandom, $urandom, 8'($urandom_range(255)));
      if (kind < 60) begin
         b.cmd = bgpt_pkg::CMD_FRAME_TICK;
         if (roll < 3) wall_us = rand64();
         else if (roll < 10) wall_us = wall_us + (rand64() >> $urandom_range(63, 20));
         else if (roll < 30) wall_us = wall_us + $urandom_range(1, 3 * tempo_hint);
         else wall_us = wall_us + $urandom_range(0, 20000);
         b.now_us = wall_us;
         if ($urandom_range(9) != 0) b.after_us = wall_us + $urandom_range(0, 15000);
      end else if (kind < 95) begin
         b.cmd    = bgpt_pkg::CMD_CONTROL;
         b.now_us = wall_us;
         if (kind < 75) begin
            b.update_flags[bgpt_pkg::FLAG_TEMPO]    = 1'b1;
            b.update_flags[bgpt_pkg::FLAG_TIME_REF] = (roll < 20);
            if (roll < 60) b.announced_period_us = $urandom_range(1500000, 200000);
            else if (roll < 80) b.announced_period_us = $urandom_range(64, 1);
            else if (roll < 90) b.announced_period_us = '0;
            if (b.announced_period_us != 0 && b.announced_period_us <= 32'd2000000)
               tempo_hint = b.announced_period_us;
         end else if (kind < 90) begin
            b.update_flags[bgpt_pkg::FLAG_TIME_REF] = 1'b1;
            b.update_flags[bgpt_pkg::FLAG_TEMPO]    = (roll < 10);
            if (roll < 10) begin
               // zero reference with a tempo restarts the grid at now
               b.announced_ref_us    = '0;
               b.announced_period_us = tempo_hint;
            end else if (roll < 85) begin
               b.announced_ref_us = wall_us - 2 * span + $urandom_range(0, 4 * tempo_hint);
            end
         end
      end
      return b;
   endfunction

   task send_beat(bgpt_pkg::req_type item);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   task wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (grid_shadow.awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task write_frame_period(logic [31:0] value);
      wait_for_drain();
      repeat (4) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      grid_shadow.frame_period = value;
   endtask

   task run_directed();
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd5000, 64'd5100, 0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_NONE, 64'd6000, 0, 64'd7, 5, 9, 8'h55));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_PROG, 64'd7000, 0, 0, 0, 0, 8'hFF));
      // time reference with no tempo yet
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF, 64'd8000, 0, 64'd1000000, 7, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd950000, 64'd951000,
                          0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TEMPO, 64'd960000, 0, 0, 0, 500000, 0));
      // last and next boundary coincide
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd970000, 64'd971000,
                          0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd1200000, 64'd1495000,
                          0, 0, 0, 0));
      // roll up, roll down, keep
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF, 64'd1300000, 0, 64'd100000, 3, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF, 64'd1300000, 0, 64'd5000000,
                          100, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF, 64'd1300000, 0, 64'd1600000,
                          9, 0, 0));
      // position equal to the span
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd1600000, 64'd1600500,
                          0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd1350000, 64'd1599990,
                          0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF | UPD_TEMPO, 64'd1700000, 0, 0,
                          0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd1800000, 64'd1800100,
                          0, 0, 0, 0));
      // grid starts from the tempo update
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF | UPD_TEMPO, 64'd2000000, 0, 0,
                          0, 250000, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd2100000, 64'd2245000,
                          0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'h8000_0000_0000_0000,
                          64'h8000_0000_0000_0001, 0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_ALL, ALL_ONES, ALL_ONES, ALL_ONES,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hAA));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, ALL_ONES, ALL_ONES,
                          0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 0, 0, 0, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TEMPO, 64'd123, 0, 0, 0, 1, 0));
      // flags mean nothing on a tick
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_ALL, 64'hFFFF_FFFF_0000_0000, 0,
                          ALL_ONES, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h11));
      send_beat(make_beat(bgpt_pkg::CMD_CONTROL, UPD_TREF, 64'd5, 0, ALL_ONES - 3, 0, 0, 0));
      send_beat(make_beat(bgpt_pkg::CMD_FRAME_TICK, UPD_NONE, 64'd10, 64'd11, 0, 0, 0, 0));
   endtask

   initial begin
      logic [31:0] period;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      wall_us = 64'd5000000 + $urandom_range(1000000);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       period = 32'd1;
            1:       period = 32'hFFFF_FFFF;
            2:       period = 32'd16667;
            3:       period = $urandom_range(32'hFFFF_FFFF, 1);
            4:       period = 32'd10000;
            default: period = $urandom_range(40000, 1);
         endcase
         write_frame_period(period);
         case (phase / 2)
            0: begin
               req_idle_pct = 16;
               rsp_idle_pct = 45;
            end
            1: begin
               req_idle_pct = 45;
               rsp_idle_pct = 16;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            // long receiver hold-off so the block backs up into the request side
            if (phase == 0 && n == 120) stall_orders = stall_orders + 1;
            if (phase == 1 && n == 60) wait_for_drain();
            send_beat(random_beat());
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (grid_shadow.awaited_rsp.size() != 0)
         grid_shadow.report_mismatch("responses never arrived",
                                     64'(grid_shadow.awaited_rsp.size()), 64'd0);
      if (grid_shadow.mismatches == 0) begin
         $display("beat_grid_phase_tracker test passed");
      end else begin
         $display("beat_grid_phase_tracker test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
